### sv/lkvc_pkg.sv
package lkvc_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_in;
        logic lookup;
        logic update;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

### sv/lkvc_if.sv
interface lkvc_req_if import lkvc_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic                    operation;
    logic signed [KEY_W-1:0] lookup_key;
    logic signed [VAL_W-1:0] write_value;

    modport source (output valid, output operation, output lookup_key, output write_value,
                    input ready);
    modport sink (input valid, input operation, input lookup_key, input write_value,
                  output ready);
endinterface

interface lkvc_resp_if import lkvc_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;

    modport source (output valid, output hit, output read_value, input ready);
    modport sink (input valid, input hit, input read_value, output ready);
endinterface

interface lkvc_cfg_if import lkvc_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/lkvc_ctrl.sv
module lkvc_ctrl
    import lkvc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOKUP = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    // Take a new transaction when idle or while the previous one retires
    always_comb begin
        o_in_ready = (r_state == ST_IDLE) ||
                     ((r_state == ST_UPDATE) && i_status.out_free);
        accept = i_in_valid && o_in_ready;
        o_cmd.load_in = accept;
        o_cmd.lookup  = (r_state == ST_LOOKUP);
        o_cmd.update  = (r_state == ST_UPDATE) && i_status.out_free;
    end

    // Advance through lookup and update
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (i_status.out_free) n_state = accept ? ST_LOOKUP : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### sv/lkvc_datapath.sv
module lkvc_datapath
    import lkvc_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    input  logic                    i_operation,
    input  logic signed [KEY_W-1:0] i_lookup_key,
    input  logic signed [VAL_W-1:0] i_write_value,
    input  logic                    i_cfg_we,
    input  logic [CAP_W-1:0]        i_cfg_data,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_hit,
    output logic signed [VAL_W-1:0] o_read_value
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    // Entry table: keys and ranks compared in parallel, values in a memory
    logic [KEY_W-1:0] r_key      [MAX_ENTRIES];
    logic [IDX_W-1:0] r_rank     [MAX_ENTRIES];
    logic [VAL_W-1:0] r_value_mem[MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [OCC_W-1:0] r_occ;
    logic [CAP_W-1:0] r_cap;

    // Request held across lookup and update
    logic             r_op;
    logic [KEY_W-1:0] r_req_key;
    logic [VAL_W-1:0] r_req_val;

    // Lookup results
    logic             r_hit;
    logic             r_use_free;
    logic [IDX_W-1:0] r_slot;
    logic [OCC_W-1:0] r_thresh;
    logic [VAL_W-1:0] r_rd_data;

    // Output register
    logic             r_out_valid;
    logic             r_out_hit;
    logic [VAL_W-1:0] r_out_val;

    logic [MAX_ENTRIES-1:0] match;
    logic             n_hit;
    logic [IDX_W-1:0] n_hit_idx;
    logic [IDX_W-1:0] n_hit_rank;
    logic [IDX_W-1:0] n_free_idx;
    logic [IDX_W-1:0] n_victim_idx;
    logic [OCC_W-1:0] occ_last;
    logic [CMP_W-1:0] eff_cap;
    logic             n_use_free;
    logic [IDX_W-1:0] n_slot;
    logic [OCC_W-1:0] n_thresh;
    logic             do_write;

    // Clamp the capacity to one .. table size
    always_comb begin
        if (r_cap == '0) begin
            eff_cap = CMP_W'(1);
        end else if (CMP_W'(r_cap) > CMP_W'(MAX_ENTRIES)) begin
            eff_cap = CMP_W'(MAX_ENTRIES);
        end else begin
            eff_cap = CMP_W'(r_cap);
        end
    end

    // Compare every entry and pick the target slot
    always_comb begin
        occ_last     = r_occ - 1'b1;
        n_hit_idx    = '0;
        n_hit_rank   = '0;
        n_victim_idx = '0;
        n_free_idx   = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            match[i] = r_valid[i] && (r_key[i] == r_req_key);
            if (match[i]) begin
                n_hit_idx  = n_hit_idx | IDX_W'(i);
                n_hit_rank = n_hit_rank | r_rank[i];
            end
            if (r_valid[i] && (OCC_W'(r_rank[i]) == occ_last)) begin
                n_victim_idx = n_victim_idx | IDX_W'(i);
            end
        end
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) n_free_idx = IDX_W'(i);
        end
        n_hit      = |match;
        n_use_free = !n_hit && (CMP_W'(r_occ) < eff_cap);
        if (n_hit) begin
            n_slot   = n_hit_idx;
            n_thresh = OCC_W'(n_hit_rank);
        end else if (n_use_free) begin
            n_slot   = n_free_idx;
            n_thresh = r_occ;
        end else begin
            n_slot   = n_victim_idx;
            n_thresh = occ_last;
        end
        do_write = (r_op == OP_PUT) || r_hit;
    end

    // Capture the request and the capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
        end
        if (i_cmd.load_in) begin
            r_op      <= i_operation;
            r_req_key <= i_lookup_key;
            r_req_val <= i_write_value;
        end
    end

    // Hold the lookup outcome and read the hit value
    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_hit      <= n_hit;
            r_use_free <= n_use_free;
            r_slot     <= n_slot;
            r_thresh   <= n_thresh;
            r_rd_data  <= r_value_mem[n_hit_idx];
        end
    end

    // Promote the target entry to most recent and, on a put, write its key and value
    always_ff @(posedge i_clk) begin
        if (i_cmd.update && do_write) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (IDX_W'(i) == r_slot) begin
                    r_rank[i] <= '0;
                end else if (r_valid[i] && (OCC_W'(r_rank[i]) < r_thresh)) begin
                    r_rank[i] <= r_rank[i] + 1'b1;
                end
            end
            if (r_op == OP_PUT) begin
                r_key[r_slot]       <= r_req_key;
                r_value_mem[r_slot] <= r_req_val;
            end
        end
    end

    // Track valid entries and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
        end else if (i_cmd.update && (r_op == OP_PUT) && !r_hit) begin
            r_valid[r_slot] <= 1'b1;
            if (r_use_free) r_occ <= r_occ + 1'b1;
        end
    end

    // Output register: load on update, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.update) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.update) begin
            r_out_hit <= r_hit;
            if (r_op == OP_PUT) begin
                r_out_val <= r_req_val;
            end else if (r_hit) begin
                r_out_val <= r_rd_data;
            end else begin
                r_out_val <= '0;
            end
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_hit             = r_out_hit;
    assign o_read_value      = r_out_val;

endmodule

### sv/lru_key_value_cache.sv
// A result is presented after its transaction passes the lookup state
// (parallel key compare) and the update state (rank and entry write); the
// update waits while the output register is full. A new transaction is taken
// only when idle or as the previous one retires. Reset: all entries invalid,
// occupancy zero, capacity 16; no clearing pass, so requests are taken at once.
module lru_key_value_cache
    import lkvc_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lkvc_req_if.sink    i_req,
    lkvc_resp_if.source o_resp,
    lkvc_cfg_if.sink    i_cfg
);

    t_cmd    cmd;
    t_status status;

    assign i_cfg.ready = 1'b1;

    lkvc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lkvc_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_operation   (i_req.operation),
        .i_lookup_key  (i_req.lookup_key),
        .i_write_value (i_req.write_value),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_data    (i_cfg.data),
        .o_out_valid   (o_resp.valid),
        .i_out_ready   (o_resp.ready),
        .o_hit         (o_resp.hit),
        .o_read_value  (o_resp.read_value)
    );

endmodule

### sim/tb_lru_key_value_cache.sv
module tb_lru_key_value_cache
    import lkvc_pkg::*;
();

    localparam int TABLE_DEPTH = 16;
    localparam int KEY_POOL_SIZE = 24;
    localparam int ITEMS_PER_SEGMENT = 150;
    localparam int REPORT_LIMIT = 10;
    localparam int unsigned CYCLE_LIMIT = 200_000;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] value;
    } t_reply;

    // Mirror of the entry table; predicts one reply per request transaction
    class lru_mirror;
        logic [KEY_W-1:0] slot_key [TABLE_DEPTH];
        logic [VAL_W-1:0] slot_value [TABLE_DEPTH];
        bit               slot_used [TABLE_DEPTH];
        int unsigned      slot_age [TABLE_DEPTH];
        int unsigned      fill = 0;
        logic [CAP_W-1:0] capacity = CAP_RESET;
        t_reply           expected_replies [$];
        int unsigned      failures = 0;

        function int unsigned pending();
            return expected_replies.size();
        endfunction

        function int unsigned usable_slots();
            if (capacity == 0)
                return 1;
            if (capacity > TABLE_DEPTH)
                return TABLE_DEPTH;
            return capacity;
        endfunction

        // Make slot s most recent; entries younger than it age by one
        function void touch(int s);
            int unsigned r;
            r = slot_age[s];
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (slot_used[i] && i != s && slot_age[i] < r)
                    slot_age[i]++;
            slot_age[s] = 0;
        endfunction

        function void note_request(logic op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
            int     s;
            int     free_slot;
            int     victim;
            t_reply r;
            s = -1;
            free_slot = -1;
            victim = -1;
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (s < 0 && slot_used[i] && slot_key[i] == key)
                    s = i;
            if (op == OP_GET) begin
                if (s >= 0) begin
                    touch(s);
                    r = '{hit: 1'b1, value: slot_value[s]};
                end else begin
                    r = '{hit: 1'b0, value: '0};
                end
            end else if (s >= 0) begin
                slot_value[s] = val;
                touch(s);
                r = '{hit: 1'b1, value: val};
            end else begin
                r = '{hit: 1'b0, value: val};
                for (int i = 0; i < TABLE_DEPTH; i++)
                    if (free_slot < 0 && !slot_used[i])
                        free_slot = i;
                if (fill < usable_slots() && free_slot >= 0) begin
                    // Insert into a free slot as most recent
                    for (int i = 0; i < TABLE_DEPTH; i++)
                        if (slot_used[i])
                            slot_age[i]++;
                    slot_used[free_slot] = 1'b1;
                    slot_key[free_slot] = key;
                    slot_value[free_slot] = val;
                    slot_age[free_slot] = 0;
                    fill++;
                end else begin
                    // Replace the least recent entry
                    for (int i = 0; i < TABLE_DEPTH; i++)
                        if (slot_used[i] && (victim < 0 || slot_age[i] > slot_age[victim]))
                            victim = i;
                    if (victim >= 0) begin
                        slot_key[victim] = key;
                        slot_value[victim] = val;
                        touch(victim);
                    end
                end
            end
            expected_replies.push_back(r);
        endfunction

        function void check_reply(logic hit, logic [VAL_W-1:0] value);
            t_reply want;
            if (expected_replies.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected reply: hit=%0b value=%0d", hit, $signed(value));
                return;
            end
            want = expected_replies.pop_front();
            if (hit !== want.hit || value !== want.value) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("reply mismatch: expected hit=%0b value=%0d, got hit=%0b value=%0d",
                             want.hit, $signed(want.value), hit, $signed(value));
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    int          req_idle_pct;
    int          resp_idle_pct;
    int unsigned cycle_count;
    logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];
    lru_mirror   mirror = new;

    lkvc_req_if  req_ch ();
    lkvc_resp_if resp_ch ();
    lkvc_cfg_if  cfg_ch ();

    lru_key_value_cache #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_resp (resp_ch),
        .i_cfg  (cfg_ch)
    );

    // Clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Stall the reply channel at random
    always @(negedge i_clk) begin
        resp_ch.ready <= ($urandom_range(99) >= resp_idle_pct);
    end

    // Check every reply transaction
    always @(posedge i_clk) begin
        if (i_rst_n && resp_ch.valid && resp_ch.ready)
            mirror.check_reply(resp_ch.hit, resp_ch.read_value);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offer one request, idling first at random; returns at the falling edge after acceptance
    task automatic send_request(logic op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
        while ($urandom_range(99) < req_idle_pct) begin
            req_ch.valid <= 1'b0;
            req_ch.operation <= 1'($urandom_range(1));
            req_ch.lookup_key <= $urandom;
            req_ch.write_value <= $urandom;
            @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.operation <= op;
        req_ch.lookup_key <= key;
        req_ch.write_value <= val;
        do
            @(posedge i_clk);
        while (!req_ch.ready);
        mirror.note_request(op, key, val);
        @(negedge i_clk);
    endtask

    // Hold off requests until every reply has come back
    task automatic drain_requests();
        req_ch.valid <= 1'b0;
        while (mirror.pending() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        drain_requests();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= cap;
        do
            @(posedge i_clk);
        while (!cfg_ch.ready);
        mirror.capacity = cap;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        cfg_ch.data <= CAP_W'($urandom);
    endtask

    // Mostly pooled keys so that hits and evictions both occur
    task automatic run_random(int count, int span);
        logic [KEY_W-1:0] key;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 80)
                key = key_pool[$urandom_range(span - 1)];
            else
                key = $urandom;
            send_request(1'($urandom_range(1)), key, $urandom);
        end
    endtask

    initial begin
        logic [CAP_W-1:0] segment_cap [6];
        int               span;
        i_rst_n = 1'b0;
        req_idle_pct = 32;
        resp_idle_pct = 54;
        cycle_count = 0;
        req_ch.valid = 1'b0;
        req_ch.operation = OP_GET;
        req_ch.lookup_key = '0;
        req_ch.write_value = '0;
        resp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        segment_cap = '{5'd16, 5'd3, 5'd1, 5'd31, 5'd0, 5'd8};
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < KEY_POOL_SIZE; i++)
            key_pool[i] = $urandom;

        // Reset
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty table, extreme keys and values, hits of both kinds
        send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(OP_PUT, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(OP_PUT, 32'hFFFF_FFFF, 32'h1234_5678);
        send_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(OP_GET, 32'h0000_0001, 32'h0000_0000);

        // Directed: capacity lowered below occupancy, one in and one out
        write_capacity(5'd2);
        send_request(OP_PUT, 32'h1111_1111, 32'hA5A5_A5A5);
        send_request(OP_PUT, 32'h2222_2222, 32'h5A5A_5A5A);
        send_request(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_request(OP_GET, 32'h8000_0000, 32'h0000_0000);

        // Directed: zero capacity acts as one
        write_capacity(5'd0);
        send_request(OP_PUT, 32'h0000_0005, 32'h0000_0005);
        send_request(OP_GET, 32'h0000_0005, 32'h0000_0000);
        send_request(OP_PUT, 32'h0000_0006, 32'h0000_0006);
        send_request(OP_GET, 32'h0000_0005, 32'h0000_0000);
        send_request(OP_GET, 32'h0000_0006, 32'h0000_0000);

        // Directed: capacity above the table size acts as the table size
        write_capacity(5'd31);
        send_request(OP_PUT, 32'h0000_0010, 32'hDEAD_BEEF);
        send_request(OP_PUT, 32'h0000_0020, 32'hCAFE_F00D);
        send_request(OP_PUT, 32'h0000_0030, 32'h0BAD_F00D);
        send_request(OP_PUT, 32'h0000_0040, 32'hFACE_B00C);
        send_request(OP_GET, 32'h0000_0010, 32'h0000_0000);

        // Random segments: new capacity each, idling profile changed every two
        for (int seg = 0; seg < 6; seg++) begin
            write_capacity(segment_cap[seg]);
            case (seg / 2)
                0: begin
                    req_idle_pct = 32;
                    resp_idle_pct = 54;
                end
                1: begin
                    req_idle_pct = 54;
                    resp_idle_pct = 32;
                end
                default: begin
                    req_idle_pct = 0;
                    resp_idle_pct = 0;
                end
            endcase
            span = mirror.usable_slots() + 4;
            if (span > KEY_POOL_SIZE)
                span = KEY_POOL_SIZE;
            run_random(ITEMS_PER_SEGMENT, span);
        end

        // Wait out the last replies
        drain_requests();
        repeat (8) @(posedge i_clk);
        if (mirror.failures == 0 && mirror.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
